[rtl/pplm_pkg.sv]
// pplm_pkg: shared constants, register indices and structs of the peak-to-peak level meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package pplm_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned SAMPLE_W    = 12;   // width of the sample and peak_to_peak fields
  localparam int unsigned CNT_W       = 12;
  localparam int unsigned WEIGHT_W    = 11;
  localparam int unsigned LEVEL_W     = 15;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam int unsigned FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned FS_ROUND    = FULL_SCALE / 2;
  localparam int unsigned LEVEL_SPAN  = 25600;
  localparam int unsigned Q10_ONE     = 1024;
  localparam int unsigned NUM_W       = 27;   // diff * LEVEL_SPAN + rounding
  localparam int unsigned SUM_W       = 28;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW_SAMPLES  = 2'd0,
    REG_NEW_WEIGHT_Q10  = 2'd1,
    REG_NOISE_THRESHOLD = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]    window_samples;
    logic [WEIGHT_W-1:0] new_weight_q10;
    logic [LEVEL_W-1:0]  noise_threshold;
  } cfg_t;

  // one closed window on its way from the front to the queue
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] diff;
  } win_t;

  // queue status seen by the back end
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] diff;
  } qhead_t;

endpackage
`default_nettype wire

[rtl/pplm_front.sv]
// pplm_front: accepts samples, tracks the window min/max and sample count, closes windows.
// Depends on pplm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pplm_front
  import pplm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic [CNT_W-1:0]    window_samples_i,
  output win_t                     win_o
);

  logic [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d, s, nmin, nmax;
  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_n, limit;
  logic                   close;

  always_comb begin
    s     = sample_i[SAMPLE_BITS-1:0];
    nmax  = (s > max_q) ? s : max_q;
    nmin  = (s < min_q) ? s : min_q;
    cnt_n = cnt_q + CNT_W'(1);
    limit = (window_samples_i == '0) ? CNT_W'(1) : window_samples_i;
    close = (cnt_n == '0) || (cnt_n >= limit);

    win_o.valid = accept_i && close;
    win_o.diff  = (nmax >= nmin) ? SAMPLE_W'(nmax - nmin) : '0;

    min_d = min_q;
    max_d = max_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (close) begin
        min_d = SAMPLE_BITS'(FULL_SCALE);
        max_d = '0;
        cnt_d = '0;
      end else begin
        min_d = nmin;
        max_d = nmax;
        cnt_d = cnt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= SAMPLE_BITS'(FULL_SCALE);
      max_q <= '0;
      cnt_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/pplm_queue.sv]
// pplm_queue: short FIFO of closed-window differences between front and back end.
// Depends on pplm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pplm_queue
  import pplm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire win_t   win_i,
  input  wire logic   pop_i,
  output qhead_t      head_o,
  output logic        full_o
);

  logic [SAMPLE_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;
  logic                pop;

  always_comb begin
    head_o.valid = (cnt_q != '0);
    head_o.diff  = mem_q[rd_q];
    full_o       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
    pop          = pop_i && head_o.valid;
    wr_d  = win_i.valid ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(win_i.valid) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (win_i.valid) begin
      mem_q[wr_q] <= win_i.diff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

[rtl/pplm_back.sv]
// pplm_back: scales a window difference to a level, smooths it, updates the noise flag.
// Three stages plus an output register; depends on pplm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pplm_back
  import pplm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire qhead_t                 head_i,
  output logic                        pop_o,
  input  wire logic [WEIGHT_W-1:0]    new_weight_q10_i,
  input  wire logic [LEVEL_W-1:0]     noise_threshold_i,
  output logic                        m_valid_o,
  input  wire logic                   m_ready_i,
  output logic [SAMPLE_W-1:0]         peak_to_peak_o,
  output logic [LEVEL_W-1:0]          smoothed_level_o,
  output logic                        noise_detected_o
);

  logic                v1_q, v2_q, v3_q, vo_q;
  logic                en1, en2, en3, eno;
  logic [SAMPLE_W-1:0] d1_q, d2_q, d3_q, do_q;
  logic [NUM_W-1:0]    num, num1_q, prod, rem;
  logic [SUM_W-1:0]    est;
  logic [LEVEL_W-1:0]  q1_q, lvl2_q, lvl_d;
  logic [LEVEL_W-1:0]  filt_q, filt_d, so_q;
  logic                flag_q, flag_d, fo_q;
  logic [WEIGHT_W-1:0] w;
  logic signed [LEVEL_W:0]    delta;
  logic signed [SUM_W-1:0]    acc;

  assign eno   = !vo_q || m_ready_i;
  assign en3   = !v3_q || eno;
  assign en2   = !v2_q || en3;
  assign en1   = !v1_q || en2;
  assign pop_o = en1 && head_i.valid;

  // level = (diff * span + FS/2) / FS, FS = 2^n - 1: reciprocal series, then one fix-up
  always_comb begin
    num  = NUM_W'(head_i.diff) * NUM_W'(LEVEL_SPAN) + NUM_W'(FS_ROUND);
    est  = SUM_W'(num) + SUM_W'(num >> SAMPLE_BITS) + SUM_W'(num >> (2 * SAMPLE_BITS));
    prod = (NUM_W'(q1_q) << SAMPLE_BITS) - NUM_W'(q1_q);
    rem  = num1_q - prod;
    lvl_d = q1_q + LEVEL_W'(rem >= NUM_W'(FULL_SCALE));
  end

  // new = old + ((level - old) * w + 512) >> 10, same as the weighted sum
  always_comb begin
    w      = (new_weight_q10_i > WEIGHT_W'(Q10_ONE)) ? WEIGHT_W'(Q10_ONE) : new_weight_q10_i;
    delta  = $signed({1'b0, lvl2_q}) - $signed({1'b0, filt_q});
    acc    = $signed({3'b000, filt_q, 10'b0}) + delta * $signed({1'b0, w})
           + $signed(SUM_W'(512));
    filt_d = acc[LEVEL_W+9:10];
    flag_d = flag_q || (filt_q > noise_threshold_i);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      d1_q   <= head_i.diff;
      num1_q <= num;
      q1_q   <= est[LEVEL_W+SAMPLE_BITS-1:SAMPLE_BITS];
    end
    if (en2) begin
      d2_q   <= d1_q;
      lvl2_q <= lvl_d;
    end
    if (en3) begin
      d3_q   <= d2_q;
    end
    if (eno) begin
      do_q <= d3_q;
      so_q <= filt_q;
      fo_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vo_q   <= 1'b0;
      filt_q <= '0;
      flag_q <= 1'b0;
    end else begin
      if (en1) v1_q <= head_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) begin
        v3_q <= v2_q;
        if (v2_q) filt_q <= filt_d;
      end
      if (eno) begin
        vo_q <= v3_q;
        if (v3_q) flag_q <= flag_d;
      end
    end
  end

  assign m_valid_o        = vo_q;
  assign peak_to_peak_o   = do_q;
  assign smoothed_level_o = so_q;
  assign noise_detected_o = fo_q;

endmodule
`default_nettype wire

[rtl/peak_to_peak_level_meter.sv]
// peak_to_peak_level_meter: top level; configuration registers, front end, queue, back end.
// Depends on pplm_pkg, pplm_front, pplm_queue, pplm_back.
//
//  channel  dir  handshake                      word
//  s_axis   in   s_axis_tvalid/s_axis_tready    [11:0] sample
//  m_axis   out  m_axis_tvalid/m_axis_tready    [11:0] peak_to_peak, [26:12] smoothed_level,
//                                               [27] noise_detected
//  cfg      in   cfg_we_i (no wait)             cfg_addr_i, cfg_wdata_i
//
// One sample per cycle while the queue is not full.
// A 4-deep queue sits between the min/max front and the 3-stage scale/filter back end;
// s_axis_tready drops only while that queue is full. The filter state loop closes through filt_q.
// Reset is immediate, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module peak_to_peak_level_meter
  import pplm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [11:0] sample
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [11:0] peak_to_peak,
                                                      // [26:12] smoothed_level,
                                                      // [27] noise_detected
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  cfg_t                cfg_q, cfg_d;
  win_t                win;
  qhead_t              head;
  logic                full, pop, accept;
  logic [SAMPLE_W-1:0] p2p;
  logic [LEVEL_W-1:0]  lvl;
  logic                flag;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_WINDOW_SAMPLES:  cfg_d.window_samples  = cfg_wdata_i[CNT_W-1:0];
        REG_NEW_WEIGHT_Q10:  cfg_d.new_weight_q10  = cfg_wdata_i[WEIGHT_W-1:0];
        REG_NOISE_THRESHOLD: cfg_d.noise_threshold = cfg_wdata_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_samples  <= CNT_W'(200);
      cfg_q.new_weight_q10  <= WEIGHT_W'(102);
      cfg_q.noise_threshold <= LEVEL_W'(12800);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  pplm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .sample_i         (s_axis_tdata[SAMPLE_W-1:0]),
    .window_samples_i (cfg_q.window_samples),
    .win_o            (win)
  );

  pplm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .win_i  (win),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  pplm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_i            (head),
    .pop_o             (pop),
    .new_weight_q10_i  (cfg_q.new_weight_q10),
    .noise_threshold_i (cfg_q.noise_threshold),
    .m_valid_o         (m_axis_tvalid),
    .m_ready_i         (m_axis_tready),
    .peak_to_peak_o    (p2p),
    .smoothed_level_o  (lvl),
    .noise_detected_o  (flag)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - SAMPLE_W - LEVEL_W - 1)'(0), flag, lvl, p2p};

endmodule
`default_nettype wire

[rtl/pplm_checker.sv]
// pplm_checker: port-level assertions for peak_to_peak_level_meter, bound to the top level.
// Depends on pplm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pplm_checker
  import pplm_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic seen_q;
  logic m_acc;

  assign m_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (m_acc && m_axis_tdata[SAMPLE_W+LEVEL_W]) begin
      seen_q <= 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result word valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[SAMPLE_W+LEVEL_W-1:SAMPLE_W] <= LEVEL_W'(LEVEL_SPAN))
    else $error("smoothed level above full scale");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && seen_q |-> m_axis_tdata[SAMPLE_W+LEVEL_W])
    else $error("noise flag cleared without reset");

endmodule

bind peak_to_peak_level_meter pplm_checker u_pplm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
